// ----- sv/poisson_cell_stencil_unit_assert.svh -----
// Assertion macros for the seven-point stencil unit.
`ifndef POISSON_CELL_STENCIL_UNIT_ASSERT_SVH
`define POISSON_CELL_STENCIL_UNIT_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define PCSU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define PCSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pcsu_pkg.sv -----
// Shared types, widths and tables for the seven-point stencil unit.
package pcsu_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int NUM_NBR      = 6;
    localparam int TYPE_BITS    = 2;
    localparam int TYPES_W      = NUM_NBR * TYPE_BITS;
    localparam int COUNT_BITS   = 3;
    localparam int RECIP_BITS   = 17;
    localparam int RECIP_SHIFT  = 16;
    localparam int WEIGHT_BITS  = 17;
    localparam int WEIGHT_SHIFT = 16;

    localparam int PAIR_W  = VALUE_BITS + 1;
    localparam int SUM_W   = VALUE_BITS + 3;
    localparam int LAP_W   = VALUE_BITS + 4;
    localparam int RESID_W = VALUE_BITS + 5;
    localparam int PROD1_W = SUM_W + RECIP_BITS + 1;
    localparam int DIFF_W  = SUM_W + 1;
    localparam int PROD2_W = DIFF_W + WEIGHT_BITS + 1;
    localparam int JAC_W   = PROD2_W - WEIGHT_SHIFT;
    localparam int FIN_W   = JAC_W + 1;

    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0]   REG_DAMPING   = '0;
    localparam logic [WEIGHT_BITS-1:0] DAMPING_RESET = WEIGHT_BITS'(43691);

    localparam logic [TYPE_BITS-1:0] NTYPE_INTERIOR  = 2'd0;
    localparam logic [TYPE_BITS-1:0] NTYPE_DIRICHLET = 2'd1;

    localparam logic signed [VALUE_BITS-1:0] SAT_HI = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] SAT_LO = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_GAUSS_SEIDEL = 2'd0,
        OP_JACOBI       = 2'd1,
        OP_RESIDUAL     = 2'd2,
        OP_APPLY        = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                       opcode;
        logic signed [VALUE_BITS-1:0]  center_value;
        logic signed [VALUE_BITS-1:0]  rhs_value;
        logic signed [VALUE_BITS-1:0]  neighbour_xm;
        logic signed [VALUE_BITS-1:0]  neighbour_xp;
        logic signed [VALUE_BITS-1:0]  neighbour_ym;
        logic signed [VALUE_BITS-1:0]  neighbour_yp;
        logic signed [VALUE_BITS-1:0]  neighbour_zm;
        logic signed [VALUE_BITS-1:0]  neighbour_zp;
        logic [TYPES_W-1:0]            neighbour_types;
        logic                          center_interior;
    } t_cell_in;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] result_value;
        logic                         saturated;
    } t_cell_out;

    typedef struct packed {
        logic                         vld;
        logic                         active;
        t_opcode                      opcode;
        logic [RECIP_BITS-1:0]        recip;
        logic signed [VALUE_BITS-1:0] center;
        logic signed [VALUE_BITS-1:0] rhs;
        logic signed [SUM_W-1:0]      sum;
        logic signed [LAP_W-1:0]      lap;
    } t_gather_out;

    function automatic logic [RECIP_BITS-1:0] recip_lookup(input logic [COUNT_BITS-1:0] count);
        logic [RECIP_BITS-1:0] r;
        case (count)
            3'd1:    r = RECIP_BITS'(65536);
            3'd2:    r = RECIP_BITS'(32768);
            3'd3:    r = RECIP_BITS'(21845);
            3'd4:    r = RECIP_BITS'(16384);
            3'd5:    r = RECIP_BITS'(13107);
            3'd6:    r = RECIP_BITS'(10923);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/pcsu_regs.sv -----
// APB register file holding the damping weight.
module pcsu_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pcsu_pkg::ADDR_W-1:0]        paddr,
    input  logic [pcsu_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pcsu_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [pcsu_pkg::WEIGHT_BITS-1:0]   o_weight
);
    import pcsu_pkg::*;

    logic [WEIGHT_BITS-1:0] r_damping_weight;
    logic                   n_wr;
    logic                   n_hit;

    assign n_hit = (paddr[ADDR_W-1:2] == REG_DAMPING);
    assign n_wr  = psel && penable && pwrite && pready && n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping_weight <= DAMPING_RESET;
        end else if (n_wr) begin
            r_damping_weight <= pwdata[WEIGHT_BITS-1:0];
        end
    end

    assign pready   = 1'b1;
    assign prdata   = n_hit ? APB_DATA_W'(r_damping_weight) : '0;
    assign o_weight = r_damping_weight;

endmodule

// ----- sv/pcsu_gather.sv -----
// Front pipeline: neighbour decode, neighbour sum, count and applied operator.
module pcsu_gather (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  pcsu_pkg::t_cell_in     i_cell,
    input  logic                   i_adv,
    output pcsu_pkg::t_gather_out  o_bus
);
    import pcsu_pkg::*;

    typedef struct packed {
        logic                         vld;
        t_opcode                      opcode;
        logic                         interior;
        logic [COUNT_BITS-1:0]        count;
        logic signed [VALUE_BITS-1:0] center;
        logic signed [VALUE_BITS-1:0] rhs;
        logic signed [PAIR_W-1:0]     pair0;
        logic signed [PAIR_W-1:0]     pair1;
        logic signed [PAIR_W-1:0]     pair2;
    } t_s1;

    typedef struct packed {
        logic                         vld;
        logic                         active;
        t_opcode                      opcode;
        logic [COUNT_BITS-1:0]        count;
        logic signed [VALUE_BITS-1:0] center;
        logic signed [VALUE_BITS-1:0] rhs;
        logic signed [SUM_W-1:0]      nsum;
    } t_s2;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_gather_out r_s3, n_s3;

    logic en1, en2, en3;

    logic signed [VALUE_BITS-1:0] nbr    [NUM_NBR];
    logic signed [VALUE_BITS-1:0] masked [NUM_NBR];
    logic [NUM_NBR-1:0]           counted;

    assign en3     = !r_s3.vld || i_adv;
    assign en2     = !r_s2.vld || en3;
    assign en1     = !r_s1.vld || en2;
    assign o_stall = !en1;

    assign nbr[0] = i_cell.neighbour_xm;
    assign nbr[1] = i_cell.neighbour_xp;
    assign nbr[2] = i_cell.neighbour_ym;
    assign nbr[3] = i_cell.neighbour_yp;
    assign nbr[4] = i_cell.neighbour_zm;
    assign nbr[5] = i_cell.neighbour_zp;

    always_comb begin
        logic [TYPE_BITS-1:0] t;
        for (int k = 0; k < NUM_NBR; k++) begin
            t          = i_cell.neighbour_types[TYPE_BITS*k +: TYPE_BITS];
            counted[k] = (t == NTYPE_INTERIOR) || (t == NTYPE_DIRICHLET);
            masked[k]  = (t == NTYPE_INTERIOR) ? nbr[k] : '0;
        end
    end

    always_comb begin
        n_s1.vld      = i_valid;
        n_s1.opcode   = i_cell.opcode;
        n_s1.interior = i_cell.center_interior;
        n_s1.count    = COUNT_BITS'($countones(counted));
        n_s1.center   = i_cell.center_value;
        n_s1.rhs      = i_cell.rhs_value;
        n_s1.pair0    = PAIR_W'(masked[0]) + PAIR_W'(masked[1]);
        n_s1.pair1    = PAIR_W'(masked[2]) + PAIR_W'(masked[3]);
        n_s1.pair2    = PAIR_W'(masked[4]) + PAIR_W'(masked[5]);
    end

    always_comb begin
        n_s2.vld    = r_s1.vld;
        n_s2.active = r_s1.interior && (r_s1.count != '0);
        n_s2.opcode = r_s1.opcode;
        n_s2.count  = r_s1.count;
        n_s2.center = r_s1.center;
        n_s2.rhs    = r_s1.rhs;
        n_s2.nsum   = SUM_W'(r_s1.pair0) + SUM_W'(r_s1.pair1) + SUM_W'(r_s1.pair2);
    end

    always_comb begin
        n_s3.vld    = r_s2.vld;
        n_s3.active = r_s2.active;
        n_s3.opcode = r_s2.opcode;
        n_s3.recip  = recip_lookup(r_s2.count);
        n_s3.center = r_s2.center;
        n_s3.rhs    = r_s2.rhs;
        n_s3.sum    = SUM_W'(r_s2.rhs) + r_s2.nsum;
        n_s3.lap    = LAP_W'($signed({1'b0, r_s2.count})) * LAP_W'(r_s2.center)
                    - LAP_W'(r_s2.nsum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (en1) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else if (en2) begin
            r_s2 <= n_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else if (en3) begin
            r_s3 <= n_s3;
        end
    end

    assign o_bus = r_s3;

endmodule

// ----- sv/pcsu_solve.sv -----
// Back pipeline: reciprocal scaling, damping, opcode select and saturation.
module pcsu_solve (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcsu_pkg::t_gather_out             i_bus,
    output logic                              o_adv,
    input  logic [pcsu_pkg::WEIGHT_BITS-1:0]  i_weight,
    output logic                              o_valid,
    input  logic                              i_stall,
    output pcsu_pkg::t_cell_out               o_result
);
    import pcsu_pkg::*;

    typedef struct packed {
        logic                         vld;
        logic                         active;
        t_opcode                      opcode;
        logic signed [VALUE_BITS-1:0] center;
        logic signed [LAP_W-1:0]      lap;
        logic signed [RESID_W-1:0]    resid;
        logic signed [PROD1_W-1:0]    prod1;
    } t_s4;

    typedef struct packed {
        logic                         vld;
        logic                         active;
        t_opcode                      opcode;
        logic signed [VALUE_BITS-1:0] center;
        logic signed [SUM_W-1:0]      gs;
        logic signed [DIFF_W-1:0]     diff;
        logic signed [RESID_W-1:0]    alt;
    } t_s5;

    typedef struct packed {
        logic                         vld;
        logic                         active;
        t_opcode                      opcode;
        logic signed [VALUE_BITS-1:0] center;
        logic signed [SUM_W-1:0]      gs;
        logic signed [RESID_W-1:0]    alt;
        logic signed [PROD2_W-1:0]    prod2;
    } t_s6;

    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_s6 r_s6, n_s6;
    t_cell_out r_out, n_out;
    logic      r_out_vld;

    logic en4, en5, en6, en_out;

    logic signed [JAC_W-1:0]   jac;
    logic signed [FIN_W-1:0]   fin;
    logic                      ovf;

    assign en_out = !r_out_vld || !i_stall;
    assign en6    = !r_s6.vld || en_out;
    assign en5    = !r_s5.vld || en6;
    assign en4    = !r_s4.vld || en5;
    assign o_adv  = en4;

    always_comb begin
        n_s4.vld    = i_bus.vld;
        n_s4.active = i_bus.active;
        n_s4.opcode = i_bus.opcode;
        n_s4.center = i_bus.center;
        n_s4.lap    = i_bus.lap;
        n_s4.resid  = RESID_W'(i_bus.rhs) - RESID_W'(i_bus.lap);
        n_s4.prod1  = PROD1_W'(i_bus.sum) * PROD1_W'($signed({1'b0, i_bus.recip}));
    end

    always_comb begin
        n_s5.vld    = r_s4.vld;
        n_s5.active = r_s4.active;
        n_s5.opcode = r_s4.opcode;
        n_s5.center = r_s4.center;
        n_s5.gs     = SUM_W'(r_s4.prod1 >>> RECIP_SHIFT);
        n_s5.diff   = DIFF_W'(n_s5.gs) - DIFF_W'(r_s4.center);
        n_s5.alt    = (r_s4.opcode == OP_RESIDUAL) ? r_s4.resid : RESID_W'(r_s4.lap);
    end

    always_comb begin
        n_s6.vld    = r_s5.vld;
        n_s6.active = r_s5.active;
        n_s6.opcode = r_s5.opcode;
        n_s6.center = r_s5.center;
        n_s6.gs     = r_s5.gs;
        n_s6.alt    = r_s5.alt;
        n_s6.prod2  = PROD2_W'(r_s5.diff) * PROD2_W'($signed({1'b0, i_weight}));
    end

    always_comb begin
        jac = JAC_W'(r_s6.prod2 >>> WEIGHT_SHIFT);
        case (r_s6.opcode)
            OP_GAUSS_SEIDEL: fin = FIN_W'(r_s6.gs);
            OP_JACOBI:       fin = FIN_W'(jac) + FIN_W'(r_s6.center);
            default:         fin = FIN_W'(r_s6.alt);
        endcase
        ovf = !((&fin[FIN_W-1:VALUE_BITS-1]) || !(|fin[FIN_W-1:VALUE_BITS-1]));
        if (!r_s6.active) begin
            n_out.result_value = '0;
            n_out.saturated    = 1'b0;
        end else if (ovf) begin
            n_out.result_value = fin[FIN_W-1] ? SAT_LO : SAT_HI;
            n_out.saturated    = 1'b1;
        end else begin
            n_out.result_value = fin[VALUE_BITS-1:0];
            n_out.saturated    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.vld <= 1'b0;
        end else if (en4) begin
            r_s4 <= n_s4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.vld <= 1'b0;
        end else if (en5) begin
            r_s5 <= n_s5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6.vld <= 1'b0;
        end else if (en6) begin
            r_s6 <= n_s6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en_out) begin
            r_out_vld <= r_s6.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

// ----- sv/poisson_cell_stencil_unit.sv -----
// Top level of the seven-point Poisson stencil unit.
// Takes one cell transaction per cycle while not stalled and returns one result per
// cell, in order. Three front stages decode the neighbour types and form the
// neighbour sum, the count and the applied operator. Four back stages scale by the
// reciprocal-of-count table, apply the damping weight, select by opcode and saturate
// into the output register. Sustained throughput is one cell per cycle while the
// output is not stalled, because every stage then takes a new cell each cycle; the
// reciprocal and weight multiplies (35 by 17 and 36 by 17 bits) each have a stage of
// their own. A stall on the output backs up only through full stages, so empty
// stages keep taking cells. The damping weight lies at byte address 0 of the APB port.
`include "poisson_cell_stencil_unit_assert.svh"
module poisson_cell_stencil_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  pcsu_pkg::t_cell_in                i_cell,
    output logic                              o_valid,
    input  logic                              i_stall,
    output pcsu_pkg::t_cell_out               o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcsu_pkg::ADDR_W-1:0]       paddr,
    input  logic [pcsu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pcsu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import pcsu_pkg::*;

    logic [WEIGHT_BITS-1:0] weight;
    t_gather_out            gather_bus;
    logic                   solve_adv;

    pcsu_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_weight (weight)
    );

    pcsu_gather u_gather (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_cell  (i_cell),
        .i_adv   (solve_adv),
        .o_bus   (gather_bus)
    );

    pcsu_solve u_solve (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bus    (gather_bus),
        .o_adv    (solve_adv),
        .i_weight (weight),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    `PCSU_ASSERT_IMP(a_sat_extreme, o_valid && o_result.saturated,
        (o_result.result_value == SAT_HI) || (o_result.result_value == SAT_LO),
        "saturated result is not a range limit")
    `PCSU_ASSERT_IMP(a_no_stall_free_out, !i_stall, !o_stall,
        "input stalled while output is free")
    `PCSU_ASSERT_IMP(a_stall_needs_full, o_stall, o_valid && gather_bus.vld,
        "input stalled with empty stages")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the seven-point Poisson stencil unit: streams cells, predicts results.
`timescale 1ns / 1ps
module tb_top;
    import pcsu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_CELLS = 1000;
    localparam longint RECIP_Q16 [0:6] = '{0, 65536, 32768, 21845, 16384, 13107, 10923};
    localparam logic signed [VALUE_BITS-1:0] ONE_Q16 = 32'sh0001_0000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_cell_in              i_cell;
    logic                  o_valid;
    logic                  i_stall;
    t_cell_out             o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_cell_out             pending_results[$];
    t_cell_out             want_result;
    logic [WEIGHT_BITS-1:0] damping_weight;
    bit                    no_idle;
    int                    errors;
    int                    cycles;
    int                    items_sent;
    int                    results_seen;
    int                    clipped_seen;
    int                    weights_used;

    poisson_cell_stencil_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_cell   (i_cell),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_cell_out predict_stencil(input t_cell_in c,
                                                  input logic [WEIGHT_BITS-1:0] w);
        longint    nbr [0:5];
        longint    nsum;
        longint    cnt;
        longint    ctr;
        longint    rhs;
        longint    wgt;
        longint    gs;
        longint    lap;
        longint    val;
        t_cell_out r;
        logic [TYPE_BITS-1:0] kind;
        nbr[0] = longint'(c.neighbour_xm);
        nbr[1] = longint'(c.neighbour_xp);
        nbr[2] = longint'(c.neighbour_ym);
        nbr[3] = longint'(c.neighbour_yp);
        nbr[4] = longint'(c.neighbour_zm);
        nbr[5] = longint'(c.neighbour_zp);
        ctr = longint'(c.center_value);
        rhs = longint'(c.rhs_value);
        wgt = longint'(w);
        nsum = 0;
        cnt = 0;
        for (int k = 0; k < NUM_NBR; k++) begin
            kind = c.neighbour_types[TYPE_BITS*k +: TYPE_BITS];
            if (kind == NTYPE_INTERIOR) begin
                nsum += nbr[k];
                cnt++;
            end else if (kind == NTYPE_DIRICHLET) begin
                cnt++;
            end
        end
        r.result_value = '0;
        r.saturated = 1'b0;
        if (c.center_interior && cnt > 0) begin
            gs = ((rhs + nsum) * RECIP_Q16[cnt]) >>> 16;
            lap = cnt * ctr - nsum;
            case (c.opcode)
                OP_GAUSS_SEIDEL: val = gs;
                OP_JACOBI:       val = ctr + (((gs - ctr) * wgt) >>> 16);
                OP_RESIDUAL:     val = rhs - lap;
                default:         val = lap;
            endcase
            if (val > longint'(SAT_HI)) begin
                r.result_value = SAT_HI;
                r.saturated = 1'b1;
            end else if (val < longint'(SAT_LO)) begin
                r.result_value = SAT_LO;
                r.saturated = 1'b1;
            end else begin
                r.result_value = val[VALUE_BITS-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = SAT_HI;
            1:       v = SAT_LO;
            2:       v = '0;
            3, 4:    v = $urandom_range(0, 1 << 21) - (1 << 20);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic t_cell_in random_cell();
        t_cell_in c;
        c.opcode = t_opcode'($urandom_range(0, 3));
        c.center_value = pick_value();
        c.rhs_value = pick_value();
        c.neighbour_xm = pick_value();
        c.neighbour_xp = pick_value();
        c.neighbour_ym = pick_value();
        c.neighbour_yp = pick_value();
        c.neighbour_zm = pick_value();
        c.neighbour_zp = pick_value();
        c.neighbour_types = TYPES_W'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            for (int k = 0; k < NUM_NBR; k++)
                c.neighbour_types[TYPE_BITS*k +: TYPE_BITS] = 2'($urandom_range(2, 3));
        end
        c.center_interior = ($urandom_range(0, 9) != 0);
        return c;
    endfunction

    function automatic t_cell_in make_cell(input t_opcode op,
                                           input logic signed [VALUE_BITS-1:0] ctr,
                                           input logic signed [VALUE_BITS-1:0] rhs,
                                           input logic signed [VALUE_BITS-1:0] nval,
                                           input logic [TYPES_W-1:0] types,
                                           input logic interior);
        t_cell_in c;
        c.opcode = op;
        c.center_value = ctr;
        c.rhs_value = rhs;
        c.neighbour_xm = nval;
        c.neighbour_xp = -nval;
        c.neighbour_ym = nval;
        c.neighbour_yp = nval;
        c.neighbour_zm = nval;
        c.neighbour_zp = nval;
        c.neighbour_types = types;
        c.center_interior = interior;
        return c;
    endfunction

    function automatic bit take_break();
        return !no_idle && ($urandom_range(0, 99) < 22);
    endfunction

    task automatic send_cell(input t_cell_in c);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cell <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results = {pending_results, predict_stencil(c, damping_weight)};
        items_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [APB_DATA_W-1:0] value);
        drain_results();
        repeat (8) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_DAMPING, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        damping_weight = value[WEIGHT_BITS-1:0];
        weights_used++;
    endtask

    task automatic check_weight_readback();
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {REG_DAMPING, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[WEIGHT_BITS-1:0] !== damping_weight) begin
            errors++;
            $display("%0t: damping weight readback expected %0d actual %0d",
                     $time, damping_weight, prdata[WEIGHT_BITS-1:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_reset_weight();
        check_weight_readback();
        send_cell(make_cell(OP_JACOBI, 3 * ONE_Q16, ONE_Q16, -ONE_Q16, 12'h000, 1'b1));
    endtask

    task automatic run_opcode_sweep();
        for (int op = 0; op < 4; op++)
            send_cell(make_cell(t_opcode'(op), -7 * ONE_Q16, 2 * ONE_Q16 + 123,
                                5 * ONE_Q16 + 77, 12'h914, 1'b1));
    endtask

    task automatic run_boundary_cases();
        send_cell(make_cell(OP_APPLY, 5 * ONE_Q16, 0, ONE_Q16, 12'h000, 1'b0));
        send_cell(make_cell(OP_GAUSS_SEIDEL, ONE_Q16, ONE_Q16, ONE_Q16, 12'hAAA, 1'b1));
        send_cell(make_cell(OP_RESIDUAL, SAT_HI, SAT_LO, SAT_HI, 12'hFFF, 1'b1));
        send_cell(make_cell(OP_APPLY, SAT_HI, 0, 0, 12'h555, 1'b1));
        send_cell(make_cell(OP_APPLY, SAT_LO, 0, 0, 12'h555, 1'b1));
        send_cell(make_cell(OP_GAUSS_SEIDEL, 0, SAT_HI, SAT_HI, 12'h000, 1'b1));
        send_cell(make_cell(OP_GAUSS_SEIDEL, 0, SAT_LO, SAT_LO, 12'h000, 1'b1));
        send_cell(make_cell(OP_RESIDUAL, SAT_LO, SAT_HI, 0, 12'h555, 1'b1));
        send_cell(make_cell(OP_RESIDUAL, SAT_HI, SAT_LO, 0, 12'h555, 1'b1));
        send_cell(make_cell(OP_JACOBI, SAT_LO, SAT_HI, SAT_HI, 12'h000, 1'b1));
        send_cell(make_cell(OP_GAUSS_SEIDEL, 0, -ONE_Q16, -3, 12'hFFC, 1'b1));
        send_cell(make_cell(OP_JACOBI, -ONE_Q16, -1, SAT_LO, 12'hFF4, 1'b1));
    endtask

    task automatic run_weight_settings();
        logic [APB_DATA_W-1:0] settings [0:4];
        settings[0] = 0;
        settings[1] = 65536;
        settings[2] = 131071;
        settings[3] = {15'($urandom), 17'd1};
        settings[4] = $urandom_range(0, 131071);
        foreach (settings[i]) begin
            write_weight(settings[i]);
            check_weight_readback();
            send_cell(make_cell(OP_JACOBI, SAT_HI, SAT_LO, SAT_LO, 12'h000, 1'b1));
            send_cell(make_cell(OP_JACOBI, 9 * ONE_Q16, ONE_Q16, -2 * ONE_Q16, 12'h451, 1'b1));
        end
    endtask

    task automatic run_random_traffic();
        no_idle = 1'b1;
        for (int n = 0; n < RANDOM_CELLS; n++) begin
            if (n == 250)
                no_idle = 1'b0;
            if (n == 500)
                drain_results();
            if (n == 650 || n == 850) begin
                write_weight($urandom_range(0, 131071));
                check_weight_readback();
            end
            send_cell(random_cell());
        end
    endtask

    always @(posedge i_clk)
        i_stall <= !no_idle && ($urandom_range(0, 99) < 22);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value %0d saturated %0b",
                         $time, o_result.result_value, o_result.saturated);
            end else begin
                want_result = pending_results.pop_front();
                if (want_result.saturated)
                    clipped_seen++;
                if (o_result.result_value !== want_result.result_value) begin
                    errors++;
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             want_result.result_value, o_result.result_value);
                end
                if (o_result.saturated !== want_result.saturated) begin
                    errors++;
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             want_result.saturated, o_result.saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_cell <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        no_idle = 1'b0;
        damping_weight = DAMPING_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_reset_weight();
        run_opcode_sweep();
        run_boundary_cases();
        run_weight_settings();
        run_random_traffic();
        drain_results();
        repeat (20) @(posedge i_clk);
        $display("sent %0d cells: all opcodes, boundary typings, clipping and %0d weights",
                 items_sent, weights_used);
        $display("checked %0d results, %0d of them clipped", results_seen, clipped_seen);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/pcsu_pkg.sv
sv/pcsu_regs.sv
sv/pcsu_gather.sv
sv/pcsu_solve.sv
sv/poisson_cell_stencil_unit.sv
bench/tb_top.sv
